// File: src/assert_macros.svh
// Assertion macros shared by the pricer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define AOBP_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the default clock and reset names.
`define AOBP_ASSERT(lbl, prop, msg) \
  `AOBP_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: src/aobp_pkg.sv
// Types, constants and arithmetic helpers for the binomial option pricer.
package aobp_pkg;

  localparam int MaxSteps = 64;
  localparam int NumCells = MaxSteps + 1;
  localparam int LvlW     = $clog2(NumCells + 1);
  localparam int CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] CfgUpFactor    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgDownFactor  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgUpProb      = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgDiscount    = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CfgStepCount   = CfgIdxW'(4);

  localparam logic [31:0] OneQ31 = 32'h8000_0000;

  // Operation broadcast to every cell of the row.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_UP,
    OP_WB,
    OP_DN_NB,
    OP_DN_OWN,
    OP_PAY,
    OP_PV,
    OP_QV,
    OP_SUM,
    OP_DISC,
    OP_DWB,
    OP_FOLD
  } cell_op_e;

  // Which cells take part in the broadcast operation.
  typedef enum logic [1:0] {
    RG_ALL,
    RG_FIRST,
    RG_REST,
    RG_BELOW
  } region_e;

  typedef struct packed {
    cell_op_e          op;
    region_e           region;
    logic [LvlW-1:0]   lvl;
  } cell_ctl_t;

  typedef struct packed {
    logic [31:0] up;
    logic [31:0] down;
    logic [31:0] prob;
    logic [31:0] qprob;
    logic [31:0] disc;
    logic [31:0] spot;
    logic [31:0] strike;
    logic        is_call;
  } coef_t;

  // Exercise value of a node.
  function automatic logic [31:0] payoff(logic [31:0] price, logic [31:0] strike,
                                         logic call);
    logic [31:0] r;
    r = 32'd0;
    if (call) begin
      if (price > strike) r = price - strike;
    end else begin
      if (strike > price) r = strike - price;
    end
    return r;
  endfunction

  // Q16.16 x Q2.30 product back to Q16.16, rounded half up; MSB flags saturation.
  function automatic logic [32:0] price_round(logic [63:0] prod);
    logic [64:0] r;
    logic [34:0] s;
    r = {1'b0, prod} + 65'h0_2000_0000;
    s = r[64:30];
    if (|s[34:32]) return {1'b1, 32'hFFFF_FFFF};
    return {1'b0, s[31:0]};
  endfunction

  // Drop 31 fraction bits, rounded half up.
  function automatic logic [31:0] round31(logic [64:0] x);
    logic [64:0] r;
    r = x + 65'h0_4000_0000;
    return r[62:31];
  endfunction

endpackage

// File: src/aobp_cell.sv
// One tree node: holds a price and a value and updates them from its neighbors.
module aobp_cell (
  input  logic                       clk_i,
  input  logic [aobp_pkg::LvlW-1:0]  idx_i,
  input  aobp_pkg::cell_ctl_t        ctl_i,
  input  aobp_pkg::coef_t            coef_i,
  input  logic [31:0]                left_price_i,
  input  logic [31:0]                right_value_i,
  output logic [31:0]                price_o,
  output logic [31:0]                value_o,
  output logic                       sat_o
);

  logic [31:0] price_q;
  logic [31:0] value_q;
  logic [31:0] v_q;
  logic [63:0] prod_q;
  logic [63:0] acc_q;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod_d;
  logic [32:0] rnd;
  logic [31:0] ex_val;
  logic        act;
  logic        count_sat;

  // Decide participation from the broadcast region
  always_comb begin
    act       = 1'b0;
    count_sat = 1'b0;
    case (ctl_i.region)
      aobp_pkg::RG_ALL: begin
        act = 1'b1;
      end
      aobp_pkg::RG_FIRST: begin
        act       = (idx_i == '0);
        count_sat = 1'b1;
      end
      aobp_pkg::RG_REST: begin
        act       = (idx_i != '0);
        count_sat = (idx_i == ctl_i.lvl);
      end
      aobp_pkg::RG_BELOW: begin
        act       = (idx_i < ctl_i.lvl);
        count_sat = 1'b1;
      end
      default: begin
        act = 1'b0;
      end
    endcase
  end

  // Select multiplier operands
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (ctl_i.op)
      aobp_pkg::OP_UP: begin
        mul_a = price_q;
        mul_b = coef_i.up;
      end
      aobp_pkg::OP_DN_NB: begin
        mul_a = left_price_i;
        mul_b = coef_i.down;
      end
      aobp_pkg::OP_DN_OWN, aobp_pkg::OP_DWB: begin
        mul_a = price_q;
        mul_b = coef_i.down;
      end
      aobp_pkg::OP_PV: begin
        mul_a = coef_i.prob;
        mul_b = value_q;
      end
      aobp_pkg::OP_QV: begin
        mul_a = coef_i.qprob;
        mul_b = right_value_i;
      end
      aobp_pkg::OP_DISC: begin
        mul_a = v_q;
        mul_b = coef_i.disc;
      end
      default: begin
        mul_a = 32'd0;
      end
    endcase
  end

  assign prod_d = 64'(mul_a) * 64'(mul_b);
  assign rnd    = aobp_pkg::price_round(prod_q);
  assign ex_val = aobp_pkg::payoff(rnd[31:0], coef_i.strike, coef_i.is_call);

  // Advance the node registers
  always_ff @(posedge clk_i) begin
    if (act) begin
      case (ctl_i.op)
        aobp_pkg::OP_LOAD: begin
          price_q <= coef_i.spot;
        end
        aobp_pkg::OP_UP, aobp_pkg::OP_DN_NB, aobp_pkg::OP_DN_OWN,
        aobp_pkg::OP_PV, aobp_pkg::OP_DISC: begin
          prod_q <= prod_d;
        end
        aobp_pkg::OP_WB: begin
          price_q <= rnd[31:0];
        end
        aobp_pkg::OP_QV: begin
          acc_q  <= prod_q;
          prod_q <= prod_d;
        end
        aobp_pkg::OP_SUM: begin
          v_q <= aobp_pkg::round31({1'b0, acc_q} + {1'b0, prod_q});
        end
        aobp_pkg::OP_DWB: begin
          v_q    <= aobp_pkg::round31({1'b0, prod_q});
          prod_q <= prod_d;
        end
        aobp_pkg::OP_FOLD: begin
          price_q <= rnd[31:0];
          value_q <= (ex_val > v_q) ? ex_val : v_q;
        end
        aobp_pkg::OP_PAY: begin
          value_q <= aobp_pkg::payoff(price_q, coef_i.strike, coef_i.is_call);
        end
        default: begin
          value_q <= value_q;
        end
      endcase
    end
  end

  assign sat_o   = act && count_sat && rnd[32] &&
                   ((ctl_i.op == aobp_pkg::OP_WB) || (ctl_i.op == aobp_pkg::OP_FOLD));
  assign price_o = price_q;
  assign value_o = value_q;

endmodule

// File: src/aobp_ctrl.sv
// Sequencer: config registers, handshakes and the per-level broadcast to the cells.
`include "assert_macros.svh"

module aobp_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [aobp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [31:0]                   spot_i,
  input  logic [31:0]                   strike_i,
  input  logic                          is_call_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [31:0]                   option_value_o,
  output logic                          saturated_o,
  output aobp_pkg::cell_ctl_t           ctl_o,
  output aobp_pkg::coef_t               coef_o,
  input  logic                          sat_i,
  input  logic [31:0]                   root_value_i
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_LOAD  = 16'h0002,
    S_UP    = 16'h0004,
    S_UPWB  = 16'h0008,
    S_DN1   = 16'h0010,
    S_DN1WB = 16'h0020,
    S_DN2   = 16'h0040,
    S_DN2WB = 16'h0080,
    S_PAY   = 16'h0100,
    S_PV    = 16'h0200,
    S_QV    = 16'h0400,
    S_SUM   = 16'h0800,
    S_DISC  = 16'h1000,
    S_DWB   = 16'h2000,
    S_FOLD  = 16'h4000,
    S_OUT   = 16'h8000
  } state_e;

  state_e                       state_q, state_d;
  logic [aobp_pkg::LvlW-1:0]    cnt_q, cnt_d;
  logic [aobp_pkg::LvlW-1:0]    n_q;
  logic [aobp_pkg::LvlW-1:0]    n_clamp;
  logic                         sat_q;
  logic                         out_valid_q;
  logic [31:0]                  out_value_q;
  logic                         out_sat_q;
  logic [31:0]                  up_q, down_q, prob_q, disc_q;
  logic [6:0]                   steps_q;
  logic [31:0]                  spot_q, strike_q;
  logic                         call_q;
  logic [31:0]                  prob_c, disc_c;
  logic                         in_xfer;
  logic                         out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Clamp configuration to the meaningful range
  assign prob_c  = (prob_q > aobp_pkg::OneQ31) ? aobp_pkg::OneQ31 : prob_q;
  assign disc_c  = (disc_q > aobp_pkg::OneQ31) ? aobp_pkg::OneQ31 : disc_q;
  assign n_clamp = (steps_q == 7'd0) ? aobp_pkg::LvlW'(1) :
                   (steps_q > 7'(aobp_pkg::MaxSteps)) ? aobp_pkg::LvlW'(aobp_pkg::MaxSteps) :
                   aobp_pkg::LvlW'(steps_q);

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q    <= 32'h4000_0000;
      down_q  <= 32'h4000_0000;
      prob_q  <= 32'h4000_0000;
      disc_q  <= aobp_pkg::OneQ31;
      steps_q <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        aobp_pkg::CfgUpFactor:   up_q    <= cfg_data_i;
        aobp_pkg::CfgDownFactor: down_q  <= cfg_data_i;
        aobp_pkg::CfgUpProb:     prob_q  <= cfg_data_i;
        aobp_pkg::CfgDiscount:   disc_q  <= cfg_data_i;
        aobp_pkg::CfgStepCount:  steps_q <= cfg_data_i[6:0];
        default:                 steps_q <= steps_q;
      endcase
    end
  end

  // Capture the option on input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      spot_q   <= spot_i;
      strike_q <= strike_i;
      call_q   <= is_call_i;
      n_q      <= n_clamp;
    end
  end

  always_comb begin
    coef_o.up      = up_q;
    coef_o.down    = down_q;
    coef_o.prob    = prob_c;
    coef_o.qprob   = aobp_pkg::OneQ31 - prob_c;
    coef_o.disc    = disc_c;
    coef_o.spot    = spot_q;
    coef_o.strike  = strike_q;
    coef_o.is_call = call_q;
  end

  // Sequence terminal build and backward folding
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    ctl_o.op      = aobp_pkg::OP_NONE;
    ctl_o.region  = aobp_pkg::RG_ALL;
    ctl_o.lvl     = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_LOAD;
      end
      S_LOAD: begin
        ctl_o.op = aobp_pkg::OP_LOAD;
        cnt_d    = aobp_pkg::LvlW'(1);
        state_d  = S_UP;
      end
      S_UP: begin
        ctl_o.op     = aobp_pkg::OP_UP;
        ctl_o.region = aobp_pkg::RG_FIRST;
        state_d      = S_UPWB;
      end
      S_UPWB: begin
        ctl_o.op     = aobp_pkg::OP_WB;
        ctl_o.region = aobp_pkg::RG_FIRST;
        if (cnt_q == n_q) begin
          cnt_d   = aobp_pkg::LvlW'(1);
          state_d = S_DN1;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_UP;
        end
      end
      S_DN1: begin
        ctl_o.op     = aobp_pkg::OP_DN_NB;
        ctl_o.region = aobp_pkg::RG_REST;
        state_d      = S_DN1WB;
      end
      S_DN1WB: begin
        ctl_o.op     = aobp_pkg::OP_WB;
        ctl_o.region = aobp_pkg::RG_REST;
        state_d      = S_DN2;
      end
      S_DN2: begin
        ctl_o.op     = aobp_pkg::OP_DN_OWN;
        ctl_o.region = aobp_pkg::RG_REST;
        state_d      = S_DN2WB;
      end
      S_DN2WB: begin
        ctl_o.op     = aobp_pkg::OP_WB;
        ctl_o.region = aobp_pkg::RG_REST;
        if (cnt_q == n_q) begin
          state_d = S_PAY;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_DN1;
        end
      end
      S_PAY: begin
        ctl_o.op = aobp_pkg::OP_PAY;
        cnt_d    = n_q;
        state_d  = S_PV;
      end
      S_PV: begin
        ctl_o.op     = aobp_pkg::OP_PV;
        ctl_o.region = aobp_pkg::RG_BELOW;
        state_d      = S_QV;
      end
      S_QV: begin
        ctl_o.op     = aobp_pkg::OP_QV;
        ctl_o.region = aobp_pkg::RG_BELOW;
        state_d      = S_SUM;
      end
      S_SUM: begin
        ctl_o.op     = aobp_pkg::OP_SUM;
        ctl_o.region = aobp_pkg::RG_BELOW;
        state_d      = S_DISC;
      end
      S_DISC: begin
        ctl_o.op     = aobp_pkg::OP_DISC;
        ctl_o.region = aobp_pkg::RG_BELOW;
        state_d      = S_DWB;
      end
      S_DWB: begin
        ctl_o.op     = aobp_pkg::OP_DWB;
        ctl_o.region = aobp_pkg::RG_BELOW;
        state_d      = S_FOLD;
      end
      S_FOLD: begin
        ctl_o.op     = aobp_pkg::OP_FOLD;
        ctl_o.region = aobp_pkg::RG_BELOW;
        if (cnt_q == aobp_pkg::LvlW'(1)) begin
          state_d = S_OUT;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          state_d = S_PV;
        end
      end
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Advance control state, accumulate saturation, hold the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (in_xfer) begin
        sat_q <= 1'b0;
      end else if (sat_i) begin
        sat_q <= 1'b1;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_value_q <= root_value_i;
      out_sat_q   <= sat_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign option_value_o = out_value_q;
  assign saturated_o    = out_sat_q;

  `AOBP_ASSERT(a_cnt_range,
    (state_q != S_IDLE && state_q != S_LOAD) |-> (cnt_q != '0 && cnt_q <= n_q),
    "level counter out of range")
  `AOBP_ASSERT(a_accept_load, in_xfer |=> (state_q == S_LOAD),
    "accepted item did not start loading")
  `AOBP_ASSERT(a_result_from_out, $rose(out_valid_q) |-> $past(state_q == S_OUT),
    "result appeared outside the output step")

endmodule

// File: src/american_option_binomial_pricer.sv
// Top level: sequencer plus the row of tree-node cells.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | write
//  in      | in_valid_i in_stall_o spot_i strike_i is_call_i | in
//  out     | out_valid_o out_stall_i option_value_o saturated_o | out
//
// For N tree levels, one option loads the spot, runs N up-steps in the first
// cell and N down rounds along the row, sets the payoff and folds back over N
// levels; each cell holds a single multiplier that all of its steps share.
// Reset clears the sequencer and output valid; configuration returns to defaults.
// A new option is taken only when the sequencer is idle; a stalled result waits
// in the output register while the next option is already taken.
module american_option_binomial_pricer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [aobp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [31:0]                   spot_i,
  input  logic [31:0]                   strike_i,
  input  logic                          is_call_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [31:0]                   option_value_o,
  output logic                          saturated_o
);

  aobp_pkg::cell_ctl_t ctl;
  aobp_pkg::coef_t     coef;
  logic [31:0]         price [aobp_pkg::NumCells];
  logic [31:0]         value [aobp_pkg::NumCells];
  logic [aobp_pkg::NumCells-1:0] sat_vec;

  aobp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .spot_i         (spot_i),
    .strike_i       (strike_i),
    .is_call_i      (is_call_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .option_value_o (option_value_o),
    .saturated_o    (saturated_o),
    .ctl_o          (ctl),
    .coef_o         (coef),
    .sat_i          (|sat_vec),
    .root_value_i   (value[0])
  );

  // Build the row; each cell sees its left price and right value
  for (genvar k = 0; k < aobp_pkg::NumCells; k++) begin : g_cell
    logic [31:0] left_price;
    logic [31:0] right_value;
    if (k == 0) begin : g_first
      assign left_price = 32'd0;
    end else begin : g_mid
      assign left_price = price[k-1];
    end
    if (k == aobp_pkg::NumCells - 1) begin : g_last
      assign right_value = 32'd0;
    end else begin : g_inner
      assign right_value = value[k+1];
    end
    aobp_cell u_cell (
      .clk_i         (clk_i),
      .idx_i         (aobp_pkg::LvlW'(k)),
      .ctl_i         (ctl),
      .coef_i        (coef),
      .left_price_i  (left_price),
      .right_value_i (right_value),
      .price_o       (price[k]),
      .value_o       (value[k]),
      .sat_o         (sat_vec[k])
    );
  end

endmodule
